// ----- rtl/core/multimeter_reading_converter_macros.svh -----
// ----------------------------------------------------------------------------
// multimeter reading converter assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MULTIMETER_READING_CONVERTER_MACROS_SVH
`define MULTIMETER_READING_CONVERTER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define MMRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mmrc assertion failed");

// next-cycle implication
`define MMRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mmrc assertion failed");

`else

`define MMRC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MMRC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/mmrc_pkg.sv -----
// ----------------------------------------------------------------------------
// mmrc_pkg
// fixed widths, register indexes, mode codes and reset values of the converter
// ----------------------------------------------------------------------------
package mmrc_pkg;

	// result width, unsigned fixed point
	localparam int READING_W = 48;

	// configuration register widths
	localparam int MODE_W   = 3;
	localparam int OHMS_W   = 24;
	localparam int MV_W     = 16;
	localparam int UV_W     = 17;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_OHMS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_MV    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UV_PER_COUNT = 2'd3;

	// measurement modes
	localparam logic [MODE_W-1:0] MODE_RES     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CURRENT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DIODE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_COND    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_VOLT    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_GAIN    = 3'd5;

	// register reset values
	localparam logic [MODE_W-1:0] MODE_RST = MODE_RES;
	localparam logic [OHMS_W-1:0] OHMS_RST = 24'd10000;
	localparam logic [MV_W-1:0]   MV_RST   = 16'd5000;
	localparam logic [UV_W-1:0]   UV_RST   = 17'd4883;

	// conductance scale, microsiemens per siemens
	localparam logic [19:0] USIEMENS_PER_S = 20'd1000000;

endpackage

// ----- rtl/core/mmrc_smul.sv -----
// ----------------------------------------------------------------------------
// mmrc_smul
// bit-serial shift-add multiplier, base times two narrow factors in two passes
// ----------------------------------------------------------------------------
module mmrc_smul #(
	parameter int W  = 44,
	parameter int FW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  base,
	input  logic [FW-1:0] f1,
	input  logic [FW-1:0] f2,
	output logic          done,
	output logic [W-1:0]  product
);

	localparam int CW = $clog2(FW + 1);

	logic          busy_q;
	logic          pass_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  mult_q;
	logic [FW-1:0] fac_q;
	logic [FW-1:0] f2_q;
	logic [W-1:0]  acc_next;

	// one factor bit per cycle, msb first
	always_comb begin
		acc_next = {acc_q[W-2:0], 1'b0} + (fac_q[FW-1] ? mult_q : '0);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pass_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				pass_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(FW - 1)) begin
					cnt_q <= '0;
					if (pass_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					pass_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			mult_q <= base;
			fac_q  <= f1;
			f2_q   <= f2;
		end else if (busy_q) begin
			if (cnt_q == CW'(FW - 1) && !pass_q) begin
				// first product becomes the base of the second pass
				acc_q  <= '0;
				mult_q <= acc_next;
				fac_q  <= f2_q;
			end else begin
				acc_q <= acc_next;
				fac_q <= {fac_q[FW-2:0], 1'b0};
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- rtl/core/mmrc_sdiv.sv -----
// ----------------------------------------------------------------------------
// mmrc_sdiv
// bit-serial restoring divider, floor(num * 2^F / den) saturated to 48 bits
// ----------------------------------------------------------------------------
module mmrc_sdiv #(
	parameter int W = 44,
	parameter int F = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [W-1:0]                   num,
	input  logic [W-1:0]                   den,
	output logic                           done,
	output logic [mmrc_pkg::READING_W-1:0] quot
);

	localparam int STEPS = W + F;
	localparam int CW    = $clog2(STEPS + 1);
	localparam int QW    = mmrc_pkg::READING_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  n_q;
	logic [W-1:0]  d_q;
	logic [W-1:0]  r_q;
	logic [QW-1:0] q_q;
	logic          sat_q;
	logic [W:0]    trial;
	logic [W+1:0]  diff;
	logic          ge;

	// one quotient bit per cycle
	always_comb begin
		trial = {r_q, n_q[W-1]};
		diff  = {1'b0, trial} - {2'b00, d_q};
		ge    = !diff[W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath, fraction zeros shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			n_q   <= {n_q[W-2:0], 1'b0};
			r_q   <= ge ? diff[W-1:0] : trial[W-1:0];
			q_q   <= {q_q[QW-2:0], ge};
			// any bit pushed out the top means the quotient overflows
			sat_q <= sat_q | q_q[QW-1];
		end
	end

	assign done = done_q;
	assign quot = sat_q ? '1 : q_q;

endmodule

// ----- rtl/core/multimeter_reading_converter.sv -----
// ----------------------------------------------------------------------------
// multimeter_reading_converter
// turns ADC samples into resistance, current, voltage, conductance or gain
// ----------------------------------------------------------------------------
// One item at a time. A measure item passes through the two bit-serial
// shift-add multipliers that build dividend and divisor, then through the
// bit-serial restoring divider, with steps for accept, handoff, compare and
// output around them. A clear item, an unused mode, a zero sample outside
// voltage mode or a zero divider resistor fails at once, without arithmetic.
// The result sits in an output register; the next item is taken while it
// waits, and a finished item holds until that register is free.
// Readings are unsigned with FRACTION_BITS fraction bits, truncated and
// saturated to all ones. Outside gain mode a reading equal to the last one
// reported comes back as success 0, reading 0.
// ----------------------------------------------------------------------------
`include "multimeter_reading_converter_macros.svh"

module multimeter_reading_converter #(
	parameter int ADC_BITS      = 10,
	parameter int FRACTION_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input items
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// sample, collector_sample, zero padding
	input  logic [((2*ADC_BITS+7)/8)*8-1:0]  s_tdata,
	// command
	input  logic                             s_tuser,
	// result items
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// reading
	output logic [mmrc_pkg::READING_W-1:0]   m_tdata,
	// success
	output logic                             m_tuser,
	// configuration writes
	input  logic                             cfg_wr_en,
	input  logic [mmrc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mmrc_pkg::CFG_W-1:0]       cfg_data
);

	localparam int W  = 2 * ADC_BITS + 24;
	localparam int FW = ADC_BITS + 1;
	localparam int RW = mmrc_pkg::READING_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [mmrc_pkg::MODE_W-1:0] mode_q;
	logic [mmrc_pkg::OHMS_W-1:0] ohms_q;
	logic [mmrc_pkg::MV_W-1:0]   mv_q;
	logic [mmrc_pkg::UV_W-1:0]   uv_q;

	logic [RW-1:0] last_q;
	logic          res_ok_q;
	logic [RW-1:0] res_val_q;
	logic          out_valid_q;
	logic          out_ok_q;
	logic [RW-1:0] out_val_q;

	logic [ADC_BITS-1:0] s_in;
	logic [ADC_BITS-1:0] c_in;
	logic [FW-1:0]       full_scale;
	logic [FW-1:0]       one_f;
	logic [FW-1:0]       fs_m_s;
	logic [FW-1:0]       fs_m_c;
	logic [W-1:0]        n_base;
	logic [FW-1:0]       n_f1;
	logic [FW-1:0]       n_f2;
	logic [W-1:0]        d_base;
	logic [FW-1:0]       d_f1;
	logic [FW-1:0]       d_f2;
	logic                fail;
	logic                accept;
	logic                mul_start;

	logic          num_done;
	logic          den_done;
	logic [W-1:0]  num_prod;
	logic [W-1:0]  den_prod;
	logic          div_done;
	logic [RW-1:0] div_quot;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mmrc_pkg::MODE_RST;
			ohms_q <= mmrc_pkg::OHMS_RST;
			mv_q   <= mmrc_pkg::MV_RST;
			uv_q   <= mmrc_pkg::UV_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mmrc_pkg::REG_MODE:         mode_q <= cfg_data[mmrc_pkg::MODE_W-1:0];
				mmrc_pkg::REG_REF_OHMS:     ohms_q <= cfg_data[mmrc_pkg::OHMS_W-1:0];
				mmrc_pkg::REG_SUPPLY_MV:    mv_q   <= cfg_data[mmrc_pkg::MV_W-1:0];
				mmrc_pkg::REG_UV_PER_COUNT: uv_q   <= cfg_data[mmrc_pkg::UV_W-1:0];
				default: ;
			endcase
		end
	end

	// sample fields and divider complements
	always_comb begin
		s_in       = s_tdata[ADC_BITS-1:0];
		c_in       = s_tdata[2*ADC_BITS-1:ADC_BITS];
		full_scale = {1'b1, {ADC_BITS{1'b0}}};
		one_f      = FW'(1);
		fs_m_s     = full_scale - {1'b0, s_in};
		fs_m_c     = full_scale - {1'b0, c_in};
	end

	// dividend and divisor factors per mode
	always_comb begin
		n_base = W'(1);
		n_f1   = one_f;
		n_f2   = one_f;
		d_base = W'(1);
		d_f1   = one_f;
		d_f2   = one_f;
		case (mode_q)
			mmrc_pkg::MODE_RES: begin
				n_base = W'(ohms_q);
				n_f1   = fs_m_s;
				d_base = W'(s_in);
			end
			mmrc_pkg::MODE_CURRENT: begin
				n_base = W'(mv_q);
				n_f1   = {1'b0, s_in};
				n_f2   = {1'b0, s_in};
				d_base = W'(ohms_q);
				d_f1   = fs_m_s;
				d_f2   = full_scale;
			end
			mmrc_pkg::MODE_DIODE: begin
				n_base = W'(mv_q);
				n_f1   = {1'b0, s_in};
				d_f1   = full_scale;
			end
			mmrc_pkg::MODE_COND: begin
				n_base = W'(mmrc_pkg::USIEMENS_PER_S);
				n_f1   = {1'b0, s_in};
				d_base = W'(ohms_q);
				d_f1   = fs_m_s;
			end
			mmrc_pkg::MODE_VOLT: begin
				n_base = W'(uv_q);
				n_f1   = {1'b0, s_in};
			end
			mmrc_pkg::MODE_GAIN: begin
				n_base = W'(fs_m_s);
				n_f1   = {1'b0, c_in};
				n_f2   = {1'b0, c_in};
				d_base = W'(fs_m_c);
				d_f1   = {1'b0, s_in};
				d_f2   = {1'b0, s_in};
			end
			default: ;
		endcase
	end

	// items that fail without arithmetic
	always_comb begin
		fail = s_tuser
			|| (mode_q > mmrc_pkg::MODE_GAIN)
			|| (s_in == '0 && mode_q != mmrc_pkg::MODE_VOLT)
			|| (c_in == '0 && mode_q == mmrc_pkg::MODE_GAIN)
			|| (ohms_q == '0 && (mode_q == mmrc_pkg::MODE_CURRENT
				|| mode_q == mmrc_pkg::MODE_COND));
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign mul_start = accept && !fail;

	// dividend and divisor, built side by side
	mmrc_smul #(
		.W  (W),
		.FW (FW)
	) u_num_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.base    (n_base),
		.f1      (n_f1),
		.f2      (n_f2),
		.done    (num_done),
		.product (num_prod)
	);

	mmrc_smul #(
		.W  (W),
		.FW (FW)
	) u_den_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.base    (d_base),
		.f1      (d_f1),
		.f2      (d_f2),
		.done    (den_done),
		.product (den_prod)
	);

	mmrc_sdiv #(
		.W (W),
		.F (FRACTION_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (num_done),
		.num    (num_prod),
		.den    (den_prod),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer, repeat suppression and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= '0;
			res_ok_q    <= 1'b0;
			res_val_q   <= '0;
			out_valid_q <= 1'b0;
			out_ok_q    <= 1'b0;
			out_val_q   <= '0;
		end else begin
			// output register drains unless a new item is loaded this cycle
			if (out_valid_q && m_tready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (fail) begin
							res_ok_q  <= 1'b0;
							res_val_q <= '0;
							if (s_tuser) begin
								last_q <= '0;
							end
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (num_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (mode_q == mmrc_pkg::MODE_GAIN) begin
							res_ok_q  <= 1'b1;
							res_val_q <= div_quot;
						end else if (div_quot == last_q) begin
							res_ok_q  <= 1'b0;
							res_val_q <= '0;
						end else begin
							res_ok_q  <= 1'b1;
							res_val_q <= div_quot;
							last_q    <= div_quot;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_ok_q    <= res_ok_q;
						out_val_q   <= res_val_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = out_val_q;

	// both multipliers run in lockstep
	`MMRC_ASSERT_IMP(a_mul_lockstep, clk, arst_n, num_done != den_done, 1'b0)
	// divider finishes only while the sequencer waits for it
	`MMRC_ASSERT_IMP(a_div_in_state, clk, arst_n, div_done, state_q == ST_DIV)
	// a clear item zeroes the last reported value
	`MMRC_ASSERT_NXT(a_clear_last, clk, arst_n, accept && s_tuser, last_q == '0)
	// a failed item never reports a nonzero reading
	`MMRC_ASSERT_IMP(a_fail_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0)

endmodule
